FILE: design/txaw_pkg.sv
// ----------------------------------------------------------------------------
// Texel address wrap/clamp package
// Shared types, widths, register indexes and the texel size table.
// ----------------------------------------------------------------------------
package txaw_pkg;

    localparam int COORD_W   = 24;
    localparam int SIZE_W    = 13;
    localparam int ADDR_W    = 40;
    localparam int BYTES_W   = 5;
    // Signed texel index width, wide enough for the smallest fraction width.
    localparam int IDX_W     = 31;
    // Magnitude width seen by the remainder pipeline and bits per stage.
    localparam int MAG_W     = 32;
    localparam int STEP_BITS = 2;
    localparam int WRAP_LAT  = MAG_W / STEP_BITS + 1;

    // Configuration register indexes.
    localparam logic [2:0] REG_SIZE_X         = 3'd0;
    localparam logic [2:0] REG_SIZE_Y         = 3'd1;
    localparam logic [2:0] REG_SIZE_Z         = 3'd2;
    localparam logic [2:0] REG_WRAP_MODES     = 3'd3;
    localparam logic [2:0] REG_TEXEL_FORMAT   = 3'd4;
    localparam logic [2:0] REG_CHANNEL_LAYOUT = 3'd5;

    // Texel formats.
    localparam logic [1:0] FMT_UBYTE  = 2'd0;
    localparam logic [1:0] FMT_USHORT = 2'd1;
    localparam logic [1:0] FMT_HALF   = 2'd2;
    localparam logic [1:0] FMT_FLOAT  = 2'd3;

    // Channel layouts.
    localparam logic [2:0] LAYOUT_R     = 3'd0;
    localparam logic [2:0] LAYOUT_RG    = 3'd1;
    localparam logic [2:0] LAYOUT_RGB   = 3'd2;
    localparam logic [2:0] LAYOUT_RGBA  = 3'd3;
    localparam logic [2:0] LAYOUT_DEPTH = 3'd4;

    typedef struct packed {
        logic signed [COORD_W-1:0] coord_u;
        logic signed [COORD_W-1:0] coord_v;
        logic signed [COORD_W-1:0] coord_w;
    } in_item_t;

    typedef struct packed {
        logic [ADDR_W-1:0]  byte_address;
        logic [BYTES_W-1:0] byte_count;
    } out_item_t;

    // Unwrapped texel indexes passed from the front end to the back end.
    typedef struct packed {
        logic signed [IDX_W-1:0] idx_u;
        logic signed [IDX_W-1:0] idx_v;
        logic signed [IDX_W-1:0] idx_w;
    } mid_item_t;

    // Effective configuration seen by the pipelines.
    typedef struct packed {
        logic [SIZE_W-1:0]  size_x;
        logic [SIZE_W-1:0]  size_y;
        logic [SIZE_W-1:0]  size_z;
        logic [2:0]         wrap_modes;
        logic [BYTES_W-1:0] byte_count;
    } cfg_t;

    // Texel size in bytes: format bytes times channel count.
    function automatic logic [BYTES_W-1:0] texel_bytes(input logic [1:0] fmt,
                                                       input logic [2:0] layout);
        logic [BYTES_W-1:0] fb;
        logic [BYTES_W-1:0] ch;
        unique case (fmt)
            FMT_UBYTE:  fb = BYTES_W'(1);
            FMT_USHORT: fb = BYTES_W'(2);
            FMT_HALF:   fb = BYTES_W'(2);
            FMT_FLOAT:  fb = BYTES_W'(4);
            default:    fb = BYTES_W'(1);
        endcase
        unique case (layout)
            LAYOUT_R:     ch = BYTES_W'(1);
            LAYOUT_RG:    ch = BYTES_W'(2);
            LAYOUT_RGB:   ch = BYTES_W'(3);
            LAYOUT_RGBA:  ch = BYTES_W'(4);
            LAYOUT_DEPTH: ch = BYTES_W'(4);
            default:      ch = BYTES_W'(1);
        endcase
        return fb * ch;
    endfunction

endpackage

FILE: design/txaw_front.sv
// ----------------------------------------------------------------------------
// Texel address front end
// Scales each coordinate by its axis size, adds one half and truncates
// toward zero, giving a signed unwrapped texel index per axis.
// ----------------------------------------------------------------------------
module txaw_front #(
    parameter int FRAC_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  txaw_pkg::cfg_t      cfg,
    input  logic                in_valid,
    output logic                in_ready,
    input  txaw_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output txaw_pkg::mid_item_t out_data
);
    import txaw_pkg::*;

    localparam int PROD_W = COORD_W + SIZE_W + 1;
    localparam int SUM_W  = PROD_W + 1;
    localparam logic signed [SUM_W-1:0] HALF     = SUM_W'(1) << (FRAC_BITS - 1);
    localparam logic signed [SUM_W-1:0] ROUND_UP = (SUM_W'(1) << FRAC_BITS) - SUM_W'(1);

    logic signed [COORD_W-1:0] coord [3];
    logic        [SIZE_W-1:0]  size  [3];
    logic signed [PROD_W-1:0]  prod_next [3];
    logic signed [PROD_W-1:0]  prod_reg  [3];
    logic signed [IDX_W-1:0]   idx_next  [3];
    logic signed [IDX_W-1:0]   idx_reg   [3];
    logic                      v1_reg;
    logic                      v2_reg;
    logic                      advance;

    assign coord[0] = in_data.coord_u;
    assign coord[1] = in_data.coord_v;
    assign coord[2] = in_data.coord_w;
    assign size[0]  = cfg.size_x;
    assign size[1]  = cfg.size_y;
    assign size[2]  = cfg.size_z;

    // The whole front end moves unless its last stage holds a blocked request.
    assign advance  = !v2_reg || out_ready;
    assign in_ready = advance;

    // Scale, then round half up and truncate toward zero.
    always_comb
    begin
        logic signed [SUM_W-1:0] sum;
        logic signed [SUM_W-1:0] adj;
        logic signed [SUM_W-1:0] shifted;
        for (int i = 0; i < 3; i++)
        begin
            prod_next[i] = $signed(coord[i]) * $signed({1'b0, size[i]});
            sum          = $signed({prod_reg[i][PROD_W-1], prod_reg[i]}) + HALF;
            adj          = sum[SUM_W-1] ? sum + ROUND_UP : sum;
            shifted      = adj >>> FRAC_BITS;
            idx_next[i]  = shifted[IDX_W-1:0];
        end
    end

    // Valid bits of the two stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (advance)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    // Stage data.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int i = 0; i < 3; i++)
            begin
                prod_reg[i] <= prod_next[i];
                idx_reg[i]  <= idx_next[i];
            end
        end
    end

    assign out_valid = v2_reg;
    assign out_data  = '{idx_u: idx_reg[0], idx_v: idx_reg[1], idx_w: idx_reg[2]};

endmodule

FILE: design/txaw_fifo.sv
// ----------------------------------------------------------------------------
// Texel address decoupling queue
// Two-entry queue between the front end and the back end.
// ----------------------------------------------------------------------------
module txaw_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  txaw_pkg::mid_item_t in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output txaw_pkg::mid_item_t out_data
);
    import txaw_pkg::*;

    mid_item_t  mem [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       push;
    logic       pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_data  = mem[rd_ptr_reg];

    // Occupancy follows pushes and pops.
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= in_data;
        end
    end

endmodule

FILE: design/txaw_wrap.sv
// ----------------------------------------------------------------------------
// Texel address wrap lane
// Applies repeat or clamp to one signed texel index. Repeat uses a
// pipelined restoring remainder, two quotient bits per stage.
// ----------------------------------------------------------------------------
module txaw_wrap (
    input  logic                          clk,
    input  logic                          en,
    input  logic signed [txaw_pkg::IDX_W-1:0]  idx,
    input  logic        [txaw_pkg::SIZE_W-1:0] size,
    input  logic                          clamp,
    output logic        [txaw_pkg::SIZE_W-1:0] index
);
    import txaw_pkg::*;

    localparam int NSTAGE = MAG_W / STEP_BITS;
    localparam int LAST   = NSTAGE - 1;

    logic [SIZE_W-1:0] rem_reg    [NSTAGE];
    logic [MAG_W-1:0]  mag_reg    [NSTAGE];
    logic              neg_reg    [NSTAGE];
    logic [SIZE_W-1:0] clampv_reg [NSTAGE];
    logic              mode_reg   [NSTAGE];
    logic [SIZE_W-1:0] rem_next   [NSTAGE];
    logic [MAG_W-1:0]  mag_next   [NSTAGE];
    logic [SIZE_W-1:0] index_reg;
    logic [SIZE_W-1:0] index_next;
    logic [SIZE_W-1:0] size_m1;
    logic              neg0;
    logic [IDX_W-1:0]  abs0;
    logic [MAG_W-1:0]  mag0;
    logic [SIZE_W-1:0] clampv0;

    // Sign, magnitude and clamped index of the incoming value.
    assign size_m1 = size - SIZE_W'(1);
    assign neg0    = idx[IDX_W-1];
    assign abs0    = neg0 ? IDX_W'(-idx) : IDX_W'(idx);
    assign mag0    = {{(MAG_W - IDX_W){1'b0}}, abs0};

    always_comb
    begin
        if (neg0)
        begin
            clampv0 = '0;
        end
        else if (idx > $signed({{(IDX_W - SIZE_W){1'b0}}, size_m1}))
        begin
            clampv0 = size_m1;
        end
        else
        begin
            clampv0 = idx[SIZE_W-1:0];
        end
    end

    // Remainder steps, STEP_BITS bits of the magnitude per stage.
    always_comb
    begin
        logic [SIZE_W-1:0] rem_v;
        logic [MAG_W-1:0]  mag_v;
        logic [SIZE_W:0]   trial;
        for (int s = 0; s < NSTAGE; s++)
        begin
            if (s == 0)
            begin
                rem_v = '0;
                mag_v = mag0;
            end
            else
            begin
                rem_v = rem_reg[s-1];
                mag_v = mag_reg[s-1];
            end
            for (int b = 0; b < STEP_BITS; b++)
            begin
                trial = {rem_v, mag_v[MAG_W-1]};
                mag_v = mag_v << 1;
                if (trial >= {1'b0, size})
                begin
                    trial = trial - {1'b0, size};
                end
                rem_v = trial[SIZE_W-1:0];
            end
            rem_next[s] = rem_v;
            mag_next[s] = mag_v;
        end
    end

    // Pick clamp, or a remainder made non-negative.
    always_comb
    begin
        if (mode_reg[LAST])
        begin
            index_next = clampv_reg[LAST];
        end
        else if (neg_reg[LAST] && (rem_reg[LAST] != '0))
        begin
            index_next = size - rem_reg[LAST];
        end
        else
        begin
            index_next = rem_reg[LAST];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int s = 0; s < NSTAGE; s++)
            begin
                rem_reg[s] <= rem_next[s];
                mag_reg[s] <= mag_next[s];
                if (s == 0)
                begin
                    neg_reg[s]    <= neg0;
                    clampv_reg[s] <= clampv0;
                    mode_reg[s]   <= clamp;
                end
                else
                begin
                    neg_reg[s]    <= neg_reg[s-1];
                    clampv_reg[s] <= clampv_reg[s-1];
                    mode_reg[s]   <= mode_reg[s-1];
                end
            end
            index_reg <= index_next;
        end
    end

    assign index = index_reg;

endmodule

FILE: design/txaw_back.sv
// ----------------------------------------------------------------------------
// Texel address back end
// Wraps or clamps the three indexes, then forms the linear texel number
// and the byte address in three multiply stages.
// ----------------------------------------------------------------------------
module txaw_back (
    input  logic                clk,
    input  logic                rst_n,
    input  txaw_pkg::cfg_t      cfg,
    input  logic                in_valid,
    output logic                in_ready,
    input  txaw_pkg::mid_item_t in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output txaw_pkg::out_item_t out_data
);
    import txaw_pkg::*;

    localparam int LAT  = WRAP_LAT + 3;
    localparam int A1_W = 2 * SIZE_W + 1;

    logic [LAT-1:0]     vld_reg;
    logic               en;
    logic [SIZE_W-1:0]  x_idx;
    logic [SIZE_W-1:0]  y_idx;
    logic [SIZE_W-1:0]  z_idx;
    logic [A1_W-1:0]    a1_reg;
    logic [SIZE_W-1:0]  xa_reg;
    logic [ADDR_W-1:0]  a2_reg;
    logic [ADDR_W-1:0]  addr_reg;
    logic [BYTES_W-1:0] bytes_reg;

    // Whole back end moves unless a finished request waits at the output.
    assign en       = !vld_reg[LAT-1] || out_ready;
    assign in_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[LAT-2:0], in_valid};
        end
    end

    txaw_wrap u_wrap_x (
        .clk   (clk),
        .en    (en),
        .idx   (in_data.idx_u),
        .size  (cfg.size_x),
        .clamp (cfg.wrap_modes[0]),
        .index (x_idx)
    );

    txaw_wrap u_wrap_y (
        .clk   (clk),
        .en    (en),
        .idx   (in_data.idx_v),
        .size  (cfg.size_y),
        .clamp (cfg.wrap_modes[1]),
        .index (y_idx)
    );

    txaw_wrap u_wrap_z (
        .clk   (clk),
        .en    (en),
        .idx   (in_data.idx_w),
        .size  (cfg.size_z),
        .clamp (cfg.wrap_modes[2]),
        .index (z_idx)
    );

    // Linear texel number x + sx * (y + sy * z), then scale by texel size.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a1_reg    <= A1_W'(z_idx) * A1_W'(cfg.size_y) + A1_W'(y_idx);
            xa_reg    <= x_idx;
            a2_reg    <= ADDR_W'(a1_reg) * ADDR_W'(cfg.size_x) + ADDR_W'(xa_reg);
            addr_reg  <= a2_reg * ADDR_W'(cfg.byte_count);
            bytes_reg <= cfg.byte_count;
        end
    end

    assign out_valid = vld_reg[LAT-1];
    assign out_data  = '{byte_address: addr_reg, byte_count: bytes_reg};

endmodule

FILE: design/texel_address_wrap_clamp_top.sv
// ----------------------------------------------------------------------------
// Texel address wrap/clamp unit
// Turns fixed-point 3D texture coordinates into a texel byte address
// and texel size, with per-axis repeat or clamp addressing.
// ----------------------------------------------------------------------------
// Usage:
// A request on the in channel carries signed u, v, w coordinates with
// COORD_FRAC_BITS fraction bits. Each request gives exactly one result on
// the out channel, in order. Both channels use valid/ready.
// Configuration is written through cfg_we/cfg_index/cfg_data while the unit
// is idle; a size of zero acts as one and sizes above MAX_SIZE saturate.
// A new request is taken every cycle while the output is not blocked.
// From request to result a request passes two scale/round stages, the
// queue, the stages of the pipelined remainder (two bits per stage over a
// 32-bit magnitude) and three address multiply stages.
// The front end and back end are parted by a two-entry queue; when the
// receiver stalls, the back end holds its result and the front end keeps
// accepting until the queue and its own stages are full.
// Reset empties all stages and sets sizes to one, other registers to zero.
// ----------------------------------------------------------------------------
module texel_address_wrap_clamp_top #(
    parameter int MAX_SIZE        = 4096,
    parameter int COORD_FRAC_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [2:0]                          cfg_index,
    input  logic [txaw_pkg::SIZE_W-1:0]         cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  txaw_pkg::in_item_t                  in_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output txaw_pkg::out_item_t                 out_data
);
    import txaw_pkg::*;

    localparam int REG_MAX  = (1 << SIZE_W) - 1;
    localparam int SIZE_CAP = (MAX_SIZE > REG_MAX) ? REG_MAX : MAX_SIZE;

    logic [SIZE_W-1:0] size_x_reg;
    logic [SIZE_W-1:0] size_y_reg;
    logic [SIZE_W-1:0] size_z_reg;
    logic [2:0]        wrap_modes_reg;
    logic [1:0]        texel_format_reg;
    logic [2:0]        channel_layout_reg;
    cfg_t              cfg;
    logic              mid_valid;
    logic              mid_ready;
    mid_item_t         mid_data;
    logic              q_valid;
    logic              q_ready;
    mid_item_t         q_data;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_x_reg         <= SIZE_W'(1);
            size_y_reg         <= SIZE_W'(1);
            size_z_reg         <= SIZE_W'(1);
            wrap_modes_reg     <= '0;
            texel_format_reg   <= '0;
            channel_layout_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SIZE_X:         size_x_reg         <= cfg_data;
                REG_SIZE_Y:         size_y_reg         <= cfg_data;
                REG_SIZE_Z:         size_z_reg         <= cfg_data;
                REG_WRAP_MODES:     wrap_modes_reg     <= cfg_data[2:0];
                REG_TEXEL_FORMAT:   texel_format_reg   <= cfg_data[1:0];
                REG_CHANNEL_LAYOUT: channel_layout_reg <= cfg_data[2:0];
                default:            ;
            endcase
        end
    end

    // Effective sizes and texel size.
    function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] s);
        if (s == '0)
        begin
            return SIZE_W'(1);
        end
        else if (s > SIZE_W'(SIZE_CAP))
        begin
            return SIZE_W'(SIZE_CAP);
        end
        return s;
    endfunction

    always_comb
    begin
        cfg.size_x     = eff_size(size_x_reg);
        cfg.size_y     = eff_size(size_y_reg);
        cfg.size_z     = eff_size(size_z_reg);
        cfg.wrap_modes = wrap_modes_reg;
        cfg.byte_count = texel_bytes(texel_format_reg, channel_layout_reg);
    end

    txaw_front #(
        .FRAC_BITS (COORD_FRAC_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (mid_valid),
        .out_ready (mid_ready),
        .out_data  (mid_data)
    );

    txaw_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (mid_valid),
        .in_ready  (mid_ready),
        .in_data   (mid_data),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_data  (q_data)
    );

    txaw_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (q_valid),
        .in_ready  (q_ready),
        .in_data   (q_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule
